### hw/rtl/sctq_pkg.sv
// Package for the searchable compacting task queue.
// Holds the item structs, the stored entry type, operation codes and sequencer states.
// Has no dependencies of its own.
`default_nettype none

package sctq_pkg;

  // Fixed field widths of the item formats.
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int OPER_W    = 3;
  localparam int POS_W     = 4;
  localparam int OCC_W     = 5;

  // Operation codes. Code seven has no meaning and fails.
  localparam logic [OPER_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OPER_W-1:0] OP_POP        = 3'd1;
  localparam logic [OPER_W-1:0] OP_DEL_HEAD   = 3'd2;
  localparam logic [OPER_W-1:0] OP_PEEK       = 3'd3;
  localparam logic [OPER_W-1:0] OP_DEL_ID     = 3'd4;
  localparam logic [OPER_W-1:0] OP_GET_ID     = 3'd5;
  localparam logic [OPER_W-1:0] OP_FIRST_OPEN = 3'd6;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // One request item.
  typedef struct packed {
    logic [OPER_W-1:0]    operation;
    logic [KEY_W-1:0]     task_key;
    logic                 new_finished;
    logic [PAYLOAD_W-1:0] new_payload;
  } req_t;

  // One result item.
  typedef struct packed {
    logic                 status;
    logic [POS_W-1:0]     entry_position;
    logic [KEY_W-1:0]     entry_key;
    logic                 entry_finished;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic [OCC_W-1:0]     occupancy;
  } rsp_t;

  // One stored queue entry.
  typedef struct packed {
    logic [KEY_W-1:0]     id;
    logic                 finished;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_READ,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/searchable_compacting_task_queue.sv
// Searchable compacting task queue: ordered bounded queue with search and delete by id.
// Entries sit in one memory; a small sequencer walks it with one shared compare unit.
// Depends on sctq_pkg.
//
//   Channel   Ports                 Direction  Handshake
//   request   start, busy, req      in         taken when start is high and busy is low
//   result    done, rsp             out        rsp valid for the one cycle done is high
//
// An unknown code goes from idle straight to the done state; insert passes through
// S_INSERT first. A search reads each entry (S_READ) and then checks it (S_CHECK), from
// the head onward, and stops at the first hit or past the last entry. A removal then
// moves each entry behind the found one up by one place, reading it (S_SHIFT_RD) and
// writing it (S_SHIFT_WR), to close the gap. The memory has a single read port with
// registered read data.
// Reset (rst, synchronous) empties the queue; entry contents are not cleared.
// The receiver cannot stall: busy stays high until the done cycle has passed.
`default_nettype none

module searchable_compacting_task_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  sctq_pkg::req_t req,
  output logic           done,
  output sctq_pkg::rsp_t rsp
);

  import sctq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  // Entry storage and its registered read data.
  entry_t mem [QUEUE_DEPTH];
  entry_t rdata;

  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  // Control and captured request.
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  req_t          cmd;

  // Result registers.
  logic          res_status;
  logic [AW-1:0] res_pos;
  entry_t        res_entry;

  logic          hit;
  logic          removing;
  logic          at_end;
  logic          shift_last;
  logic          full;
  logic [31:0]   pos_wide;
  logic [31:0]   occ_wide;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign at_end     = (idx == count);
  assign shift_last = ((idx + CW'(1)) == count);

  // Shared compare unit: decides whether the entry just read is the one sought.
  always_comb begin
    case (cmd.operation)
      OP_POP, OP_DEL_HEAD, OP_PEEK: hit = 1'b1;
      OP_DEL_ID, OP_GET_ID:         hit = (rdata.id == cmd.task_key);
      OP_FIRST_OPEN:                hit = !rdata.finished;
      default:                      hit = 1'b0;
    endcase
  end

  // Operations that take the found entry out of the queue.
  always_comb begin
    case (cmd.operation)
      OP_POP, OP_DEL_HEAD, OP_DEL_ID: removing = 1'b1;
      default:                        removing = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.operation == OP_INSERT) begin
            state_next = S_INSERT;
          end else if (req.operation inside {[OP_POP:OP_FIRST_OPEN]}) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_INSERT:   state_next = S_DONE;
      S_READ:     state_next = at_end ? S_DONE : S_CHECK;
      S_CHECK: begin
        if (hit) begin
          state_next = removing ? S_SHIFT_RD : S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_SHIFT_RD: state_next = shift_last ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory port controls for each state.
  always_comb begin
    rd_addr = idx[AW-1:0];
    mem_we  = 1'b0;
    waddr   = idx[AW-1:0];
    wdata   = rdata;
    case (state)
      S_INSERT: begin
        mem_we = !full;
        waddr  = count[AW-1:0];
        wdata  = '{id: cmd.task_key, finished: cmd.new_finished, payload: cmd.new_payload};
      end
      S_SHIFT_RD: begin
        rd_addr = AW'(idx + CW'(1));
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // Sequencer state and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_INSERT && !full) begin
        count <= count + CW'(1);
      end else if (state == S_SHIFT_RD && shift_last) begin
        count <= count - CW'(1);
      end
    end
  end

  // Scan index, captured request and result fields.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd        <= req;
          idx        <= '0;
          res_status <= STATUS_FAIL;
          res_pos    <= '0;
          res_entry  <= '0;
        end
      end
      S_INSERT: begin
        if (!full) begin
          res_status <= STATUS_OK;
          res_pos    <= count[AW-1:0];
          res_entry  <= wdata;
        end
      end
      S_CHECK: begin
        if (hit) begin
          res_status <= STATUS_OK;
          res_pos    <= idx[AW-1:0];
          res_entry  <= rdata;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      S_SHIFT_WR: begin
        idx <= idx + CW'(1);
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Result port.
  assign pos_wide = 32'(res_pos);
  assign occ_wide = 32'(count);

  always_comb begin
    busy                = (state != S_IDLE);
    done                = (state == S_DONE);
    rsp.status          = res_status;
    rsp.entry_position  = pos_wide[POS_W-1:0];
    rsp.entry_key       = res_entry.id;
    rsp.entry_finished  = res_entry.finished;
    rsp.entry_payload   = res_entry.payload;
    rsp.occupancy       = occ_wide[OCC_W-1:0];
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("occupancy exceeds queue depth");

  // Occupancy moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == $past(count) + CW'(1)
              || count == $past(count) - CW'(1)))
    else $error("occupancy jumped by more than one");

  // A failed result carries zero entry fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_FAIL) |->
      (rsp.entry_key == '0 && rsp.entry_payload == '0 &&
       rsp.entry_position == '0 && !rsp.entry_finished))
    else $error("failed result carries entry data");

  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");
`endif

endmodule

`default_nettype wire

### test/sctq_checker.sv
// Checker for the searchable compacting task queue: watches the request and result
// channels, keeps its own copy of the queue, and compares every result it sees.
// Depends on sctq_pkg.
`timescale 1ns / 100ps

module sctq_checker #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  sctq_pkg::req_t req,
  input  logic           done,
  input  sctq_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);
  import sctq_pkg::*;

  // Our own picture of the queue contents, head at index zero.
  entry_t held [DEPTH];
  int     held_count;

  // Results owed by the block, oldest first.
  rsp_t queued_outcomes [$];

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("sctq_checker: %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  // Applies one operation to the held queue and returns the result it must give.
  function automatic rsp_t task_queue_op(input req_t item);
    rsp_t outcome;
    int   hit;
    bit   found;
    outcome = '0;
    hit     = 0;
    found   = 1'b0;
    case (item.operation)
      OP_INSERT: begin
        if (held_count < DEPTH) begin
          hit = held_count;
          held[hit].id       = item.task_key;
          held[hit].finished = item.new_finished;
          held[hit].payload  = item.new_payload;
          held_count++;
          found = 1'b1;
        end
      end
      OP_POP, OP_DEL_HEAD, OP_PEEK: begin
        if (held_count > 0) begin
          found = 1'b1;
        end
      end
      OP_DEL_ID, OP_GET_ID, OP_FIRST_OPEN: begin
        // The entry nearest the head wins when several match.
        for (int i = 0; i < held_count && !found; i++) begin
          if (item.operation == OP_FIRST_OPEN ? !held[i].finished
                                              : held[i].id == item.task_key) begin
            hit   = i;
            found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (found) begin
      outcome.status         = STATUS_OK;
      outcome.entry_position = hit[POS_W-1:0];
      outcome.entry_key      = held[hit].id;
      outcome.entry_finished = held[hit].finished;
      outcome.entry_payload  = held[hit].payload;
      // Removing operations close up the gap behind the removed entry.
      if (item.operation == OP_POP || item.operation == OP_DEL_HEAD ||
          item.operation == OP_DEL_ID) begin
        for (int i = hit; i + 1 < held_count; i++) begin
          held[i] = held[i + 1];
        end
        held_count--;
      end
    end else begin
      outcome.status = STATUS_FAIL;
    end
    outcome.occupancy = held_count[OCC_W-1:0];
    return outcome;
  endfunction

  // Compare results as they come, then record the result owed for a newly taken item.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      held_count = 0;
      queued_outcomes.delete();
    end else begin
      if (done) begin
        if (queued_outcomes.size() == 0) begin
          report_mismatch("result with no item outstanding, status", 32'(rsp.status), 0);
        end else begin
          want = queued_outcomes.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.entry_position !== want.entry_position)
            report_mismatch("entry_position", 32'(rsp.entry_position),
                            32'(want.entry_position));
          if (rsp.entry_key !== want.entry_key)
            report_mismatch("entry_key", rsp.entry_key, want.entry_key);
          if (rsp.entry_finished !== want.entry_finished)
            report_mismatch("entry_finished", 32'(rsp.entry_finished),
                            32'(want.entry_finished));
          if (rsp.entry_payload !== want.entry_payload)
            report_mismatch("entry_payload", rsp.entry_payload, want.entry_payload);
          if (rsp.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
        end
      end
      if (start && !busy) begin
        queued_outcomes.push_back(task_queue_op(req));
      end
    end
    pending <= queued_outcomes.size();
  end

endmodule

### test/tb_top.sv
// Top of the testbench for the searchable compacting task queue: clock, reset,
// directed and random items, and the final verdict. Depends on sctq_pkg, the block
// and sctq_checker.
`timescale 1ns / 100ps

module tb_top;
  import sctq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RANDOM_ITEMS  = 1630;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int POOL_SIZE     = 8;

  // Code seven carries no operation; the block must fail it.
  localparam logic [OPER_W-1:0] OP_UNUSED = 3'd7;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  int fail_count;
  int pending;
  int cycles = 0;
  bit quiet  = 1'b0;

  // Ids that random items insert and search for, so that searches mostly hit.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  searchable_compacting_task_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  sctq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Waits a random gap, then offers one item until the block takes it.
  // Quiet stretches offer items back to back.
  task automatic issue(input req_t item);
    int gap;
    if ($urandom_range(0, 29) == 0) quiet = !quiet;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic send(input logic [OPER_W-1:0] op, input logic [KEY_W-1:0] key,
                      input logic fin, input logic [PAYLOAD_W-1:0] pay);
    req_t item;
    item.operation    = op;
    item.task_key     = key;
    item.new_finished = fin;
    item.new_payload  = pay;
    issue(item);
  endtask

  // Draws one random item; while filling, inserts dominate, otherwise searches and removals do.
  function automatic req_t random_item(input bit filling);
    req_t item;
    int   roll;
    item.task_key     = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 9) == 0) item.task_key = $urandom;
    item.new_finished = 1'($urandom_range(0, 1));
    item.new_payload  = $urandom;
    if ($urandom_range(0, 99) < (filling ? 60 : 15)) begin
      item.operation = OP_INSERT;
    end else begin
      roll = $urandom_range(0, 19);
      if (roll < 3)       item.operation = OP_POP;
      else if (roll < 6)  item.operation = OP_DEL_HEAD;
      else if (roll < 8)  item.operation = OP_PEEK;
      else if (roll < 11) item.operation = OP_DEL_ID;
      else if (roll < 14) item.operation = OP_GET_ID;
      else if (roll < 19) item.operation = OP_FIRST_OPEN;
      else                item.operation = OP_UNUSED;
    end
    return item;
  endfunction

  initial begin
    bit filling;
    filling = 1'b1;
    foreach (key_pool[i]) key_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every operation on an empty queue fails.
    send(OP_POP,        32'h0,        1'b0, 32'h0);
    send(OP_DEL_HEAD,   32'h0,        1'b0, 32'h0);
    send(OP_PEEK,       32'h0,        1'b0, 32'h0);
    send(OP_DEL_ID,     32'h0,        1'b0, 32'h0);
    send(OP_GET_ID,     32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
    send(OP_FIRST_OPEN, 32'h0,        1'b0, 32'h0);
    send(OP_UNUSED,     32'h0,        1'b0, 32'h0);

    // Extreme ids and payloads, a duplicate id, both flag values.
    send(OP_INSERT, 32'h00000000, 1'b1, 32'h00000000);
    send(OP_INSERT, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
    send(OP_INSERT, 32'h12345678, 1'b0, 32'hA5A5A5A5);
    send(OP_INSERT, 32'hFFFFFFFF, 1'b0, 32'h5A5A5A5A);
    send(OP_INSERT, 32'h80000001, 1'b1, 32'h00000001);

    // Searches, the duplicate resolving to the entry nearest the head, then removals and the unused code.
    send(OP_GET_ID,     32'hFFFFFFFF, 1'b0, 32'h0);
    send(OP_GET_ID,     32'h0BADF00D, 1'b0, 32'h0);
    send(OP_FIRST_OPEN, 32'h0,        1'b0, 32'h0);
    send(OP_PEEK,       32'h0,        1'b0, 32'h0);
    send(OP_DEL_ID,     32'h12345678, 1'b0, 32'h0);
    send(OP_UNUSED,     32'h0,        1'b1, 32'hFFFFFFFF);
    send(OP_POP,        32'h0,        1'b0, 32'h0);
    send(OP_DEL_HEAD,   32'h0,        1'b0, 32'h0);
    send(OP_DEL_ID,     32'h0BADF00D, 1'b0, 32'h0);

    // Random phases alternate between filling toward full and draining toward empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) filling = !filling;
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      issue(random_item(filling));
    end
    start <= 1'b0;

    // Drain the outstanding results, then give the block time for any stray one.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
